>>> src/ttg_pkg.sv
// Shared types, widths and constants of the trapezoidal trajectory generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ttg_pkg;

    // Fraction bits of the position format.
    localparam int POS_FRAC_BITS = 16;
    // Fraction bits of the time value built from the tick counter.
    localparam int TICK_FRAC_BITS = 16;

    // Field widths.
    localparam int POS_W = 48;
    localparam int VEL_W = 32;
    localparam int RATE_W = 32;
    localparam int TGT_W = 32;

    // Serial multiplier operand width: operands stay below 2^50.
    localparam int MUL_W = 50;

    // Serial divider widths: the widest numerator of any division
    // and a denominator of up to twice a 32-bit rate.
    localparam int NUM_A = 64 + POS_FRAC_BITS - 8;
    localparam int NUM_B = 49 + 32 - POS_FRAC_BITS;
    localparam int NUM_AB = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int DIV_NUM_W = (NUM_AB > 56) ? NUM_AB : 56;
    localparam int DIV_DEN_W = 33;

    // Caps of capped products and quotients.
    localparam logic [MUL_W-1:0] BIG_CAP = 50'h2_0000_0000_0000;
    localparam logic [MUL_W-1:0] TIME_MAX = 50'h0_7FFF_FFFF_FFFF;

    // Motion phase codes.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ACC  = 2'd1,
        PH_CRU  = 2'd2,
        PH_DEC  = 2'd3
    } phase_t;

endpackage

>>> src/ttg_in_if.sv
// Request channel of the trajectory generator: valid, ready and one request.
// Depends on ttg_pkg for field widths.
`timescale 1ns / 1ps

interface ttg_in_if
    import ttg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [TGT_W-1:0]  target_position;
    logic [VEL_W-1:0]  cruise_velocity;
    logic [RATE_W-1:0] accel_rate;
    logic [RATE_W-1:0] decel_rate;

    modport source (
        output valid, func, target_position, cruise_velocity, accel_rate, decel_rate,
        input  ready
    );

    modport sink (
        input  valid, func, target_position, cruise_velocity, accel_rate, decel_rate,
        output ready
    );
endinterface

>>> src/ttg_out_if.sv
// Result channel of the trajectory generator: valid, ready and one setpoint request.
// Depends on ttg_pkg for field widths.
`timescale 1ns / 1ps

interface ttg_out_if
    import ttg_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position_setpoint;
    logic [VEL_W-1:0] velocity_setpoint;
    logic [1:0]       phase;
    logic             move_done;
    logic             move_pending;
    logic             command_refused;

    modport source (
        output valid, position_setpoint, velocity_setpoint, phase, move_done,
               move_pending, command_refused,
        input  ready
    );

    modport sink (
        input  valid, position_setpoint, velocity_setpoint, phase, move_done,
               move_pending, command_refused,
        output ready
    );
endinterface

>>> src/ttg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ttg_pkg for the operand width.
`timescale 1ns / 1ps

module ttg_mul
    import ttg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 done,
    output logic [2*MUL_W-1:0]   prod
);
    localparam int CNT_W = $clog2(MUL_W + 1);

    logic [2*MUL_W-1:0] p_reg;
    logic [2*MUL_W-1:0] p_next;
    logic [MUL_W-1:0]   a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     sum;

    // Add the multiplicand into the upper half when the low bit is set, then shift right.
    always_comb
    begin
        sum = {1'b0, p_reg[2*MUL_W-1:MUL_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        p_next = {sum, p_reg[MUL_W-1:1]};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{MUL_W{1'b0}}, b};
            a_reg <= a;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done = done_reg;
    assign prod = p_reg;
endmodule

>>> src/ttg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ttg_pkg for the numerator and denominator widths.
`timescale 1ns / 1ps

module ttg_div
    import ttg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] n_reg;
    logic [DIV_DEN_W-1:0] r_reg;
    logic [DIV_DEN_W-1:0] d_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rs;
    logic [DIV_DEN_W:0]   rd;
    logic                 ge;

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        rs = {r_reg, n_reg[DIV_NUM_W-1]};
        rd = rs - {1'b0, d_reg};
        ge = (rs >= {1'b0, d_reg});
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the numerator register fills with quotient bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[DIV_NUM_W-2:0], ge};
            r_reg <= ge ? rd[DIV_DEN_W-1:0] : rs[DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo = n_reg;
endmodule

>>> src/trapezoidal_trajectory_generator_top.sv
// Top level of the single-axis trapezoidal trajectory generator.
// Depends on ttg_pkg, ttg_in_if, ttg_out_if, ttg_mul and ttg_div.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one request per handshake: func=1 loads a move command
// (target, cruise velocity, acceleration, deceleration) into a one-slot pending
// buffer, func=0 advances time by one interpolation tick. Every request yields
// exactly one setpoint request on the rsp channel (position, velocity, phase,
// done, pending and refused flags).
// Sequencing: a command, or a tick with nothing to do, goes straight to the output
// stage. A running tick passes through one evaluation step for each phase it visits
// and runs zero to three products on the shared bit-serial multiplier. A tick that
// starts a move first runs six divisions and two products to plan its phases.
// One request is worked on at a time; req.ready is high only while the sequencer
// waits. A finished setpoint waits in the output register while the receiver
// stalls, and the next request is still taken in the meantime.
// Reset clears the phase to idle, the position and velocity to zero and all flags.

module trapezoidal_trajectory_generator_top
    import ttg_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    ttg_in_if.sink    req,
    ttg_out_if.source rsp
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_PUT   = 5'b10000
    } state_t;

    // Arithmetic steps of move start and of one tick.
    typedef enum logic [3:0] {
        OP_T1, OP_VV, OP_S1, OP_Q, OP_VA, OP_VD, OP_S2, OP_T3,
        OP_AV, OP_AP, OP_CP, OP_DV, OP_DF, OP_DB
    } op_t;

    localparam logic signed [63:0] POS_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN64 = 64'shFFFF_8000_0000_0000;
    localparam logic [63:0] E_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] E_CAP = 64'h0000_0001_0000_0000;

    function automatic logic signed [63:0] sx48(input logic [POS_W-1:0] x);
        return $signed({{(64-POS_W){x[POS_W-1]}}, x});
    endfunction

    function automatic logic signed [63:0] zx50(input logic [MUL_W-1:0] x);
        return $signed({{(64-MUL_W){1'b0}}, x});
    endfunction

    function automatic logic [POS_W-1:0] sat48(input logic signed [63:0] x);
        logic [POS_W-1:0] r;
        if (x > POS_MAX64)
        begin
            r = POS_MAX64[POS_W-1:0];
        end
        else if (x < POS_MIN64)
        begin
            r = POS_MIN64[POS_W-1:0];
        end
        else
        begin
            r = x[POS_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    phase_t phase_reg, phase_next;

    logic                pending_valid_reg, pending_valid_next;
    logic [TGT_W-1:0]    pend_tgt_reg, pend_tgt_next;
    logic [VEL_W-1:0]    pend_vel_reg, pend_vel_next;
    logic [RATE_W-1:0]   pend_acc_reg, pend_acc_next;
    logic [RATE_W-1:0]   pend_dec_reg, pend_dec_next;
    logic [VEL_W-1:0]    act_vel_reg, act_vel_next;
    logic [RATE_W-1:0]   act_acc_reg, act_acc_next;
    logic [RATE_W-1:0]   act_dec_reg, act_dec_next;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [POS_W-1:0]    t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic [POS_W-1:0]    s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    logic [POS_W-1:0]    tgt_fix_reg, tgt_fix_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [VEL_W-1:0]    vel_reg, vel_next;
    logic                done_reg, done_next;
    logic                refused_reg, refused_next;
    logic [63:0]         vv_reg, vv_next;
    logic signed [63:0]  tacc_reg, tacc_next;
    logic [MUL_W-1:0]    at_reg, at_next;
    logic [MUL_W-1:0]    dv_reg, dv_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    logic [POS_W-1:0]    out_pos_reg;
    logic [VEL_W-1:0]    out_vel_reg;
    phase_t              out_phase_reg;
    logic                out_done_reg;
    logic                out_pend_reg;
    logic                out_ref_reg;

    logic                 mul_start, mul_done;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_prod, mul_shifted;
    logic [MUL_W-1:0]     mul_cap;
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic [MUL_W-1:0]     div_res;
    logic                 op_is_div, unit_done;

    logic [63:0]          e64, e_cl;
    logic [48:0]          t_cur;
    logic signed [63:0]   t_s;
    logic signed [63:0]   dd1, dd2, td1, td2, dt_t1, dt_t2;
    logic                 dist_neg, dt21_neg;
    logic [48:0]          dist_mag, dt21_mag;
    logic signed [63:0]   tgt_ext;

    ttg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ttg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Time of the current tick and the differences that feed the operands.
    always_comb
    begin
        e64 = 64'(elapsed_reg);
        e_cl = (e64 > E_MAX) ? E_CAP : e64;
        t_cur = {e_cl[32:0], {TICK_FRAC_BITS{1'b0}}};
        t_s = $signed({15'b0, t_cur});
        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
        dd1 = sx48(tgt_fix_reg) - sx48(s0_reg);
        dd2 = sx48(s0_reg) - sx48(tgt_fix_reg);
        dist_neg = dd1[63];
        dist_mag = dist_neg ? dd2[48:0] : dd1[48:0];
        td1 = sx48(t2_reg) - sx48(t1_reg);
        td2 = sx48(t1_reg) - sx48(t2_reg);
        dt21_neg = td1[63];
        dt21_mag = dt21_neg ? td2[48:0] : td1[48:0];
        dt_t1 = t_s - sx48(t1_reg);
        dt_t2 = t_s - sx48(t2_reg);
        tgt_ext = $signed({{(64-TGT_W){pend_tgt_reg[TGT_W-1]}}, pend_tgt_reg});
    end

    // Which unit an operation uses.
    always_comb
    begin
        case (op_reg) inside
            OP_T1, OP_S1, OP_Q, OP_VA, OP_VD, OP_T3: op_is_div = 1'b1;
            default:                                 op_is_div = 1'b0;
        endcase
        unit_done = op_is_div ? div_done : mul_done;
    end

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_num = '0;
        div_den = '0;
        case (op_reg)
            OP_T1:
            begin
                div_num = DIV_NUM_W'(act_vel_reg) << 24;
                div_den = DIV_DEN_W'(act_acc_reg);
            end
            OP_VV:
            begin
                mul_a = MUL_W'(act_vel_reg);
                mul_b = MUL_W'(act_vel_reg);
            end
            OP_S1:
            begin
                div_num = DIV_NUM_W'(vv_reg) << (POS_FRAC_BITS - 8);
                div_den = {act_acc_reg, 1'b0};
            end
            OP_Q:
            begin
                div_num = DIV_NUM_W'(dist_mag) << (32 - POS_FRAC_BITS);
                div_den = DIV_DEN_W'(act_vel_reg);
            end
            OP_VA:
            begin
                div_num = DIV_NUM_W'(act_vel_reg) << 23;
                div_den = DIV_DEN_W'(act_acc_reg);
            end
            OP_VD:
            begin
                div_num = DIV_NUM_W'(act_vel_reg) << 23;
                div_den = DIV_DEN_W'(act_dec_reg);
            end
            OP_S2:
            begin
                mul_a = MUL_W'(act_vel_reg);
                mul_b = MUL_W'(dt21_mag);
            end
            OP_T3:
            begin
                div_num = DIV_NUM_W'(act_vel_reg) << 24;
                div_den = DIV_DEN_W'(act_dec_reg);
            end
            OP_AV:
            begin
                mul_a = MUL_W'(act_acc_reg);
                mul_b = MUL_W'(t_cur);
            end
            OP_AP:
            begin
                mul_a = at_reg;
                mul_b = MUL_W'(t_cur);
            end
            OP_CP:
            begin
                mul_a = MUL_W'(act_vel_reg);
                mul_b = dt_t1[MUL_W-1:0];
            end
            OP_DV:
            begin
                mul_a = MUL_W'(act_dec_reg);
                mul_b = dt_t2[MUL_W-1:0];
            end
            OP_DF:
            begin
                mul_a = MUL_W'(act_vel_reg);
                mul_b = dt_t2[MUL_W-1:0];
            end
            OP_DB:
            begin
                mul_a = dv_reg;
                mul_b = dt_t2[MUL_W-1:0];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Scale and cap the unit results.
    always_comb
    begin
        case (op_reg) inside
            OP_AV, OP_DV: mul_shifted = mul_prod >> 24;
            OP_AP, OP_DB: mul_shifted = mul_prod >> (33 - POS_FRAC_BITS);
            default:      mul_shifted = mul_prod >> (32 - POS_FRAC_BITS);
        endcase
        mul_cap = (mul_shifted > (2*MUL_W)'(BIG_CAP)) ? BIG_CAP : mul_shifted[MUL_W-1:0];
        case (op_reg) inside
            OP_T1, OP_VA, OP_VD, OP_T3:
                div_res = (div_quo > DIV_NUM_W'(TIME_MAX)) ? TIME_MAX
                                                            : div_quo[MUL_W-1:0];
            default:
                div_res = (div_quo > DIV_NUM_W'(BIG_CAP)) ? BIG_CAP
                                                           : div_quo[MUL_W-1:0];
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        phase_next = phase_reg;
        pending_valid_next = pending_valid_reg;
        pend_tgt_next = pend_tgt_reg;
        pend_vel_next = pend_vel_reg;
        pend_acc_next = pend_acc_reg;
        pend_dec_next = pend_dec_reg;
        act_vel_next = act_vel_reg;
        act_acc_next = act_acc_reg;
        act_dec_next = act_dec_reg;
        elapsed_next = elapsed_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        s0_next = s0_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        tgt_fix_next = tgt_fix_reg;
        pos_next = pos_reg;
        vel_next = vel_reg;
        done_next = done_reg;
        refused_next = refused_reg;
        vv_next = vv_reg;
        tacc_next = tacc_reg;
        at_next = at_reg;
        dv_next = dv_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func)
                    begin
                        // Move command: refused when any speed or rate is zero.
                        if (req.cruise_velocity == '0 || req.accel_rate == '0
                            || req.decel_rate == '0)
                        begin
                            refused_next = 1'b1;
                        end
                        else
                        begin
                            refused_next = 1'b0;
                            pend_tgt_next = req.target_position;
                            pend_vel_next = req.cruise_velocity;
                            pend_acc_next = req.accel_rate;
                            pend_dec_next = req.decel_rate;
                            pending_valid_next = 1'b1;
                            done_next = 1'b0;
                        end
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        refused_next = 1'b0;
                        if (phase_reg == PH_IDLE && pending_valid_reg)
                        begin
                            // Start the pending move and plan its phases.
                            act_vel_next = pend_vel_reg;
                            act_acc_next = pend_acc_reg;
                            act_dec_next = pend_dec_reg;
                            pending_valid_next = 1'b0;
                            tgt_fix_next = sat48(tgt_ext <<< POS_FRAC_BITS);
                            s0_next = pos_reg;
                            op_next = OP_T1;
                            state_next = ST_ISSUE;
                        end
                        else if (phase_reg != PH_IDLE)
                        begin
                            state_next = ST_EVAL;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                end
            end

            ST_EVAL:
            begin
                // Phase end check; a reached end falls through to the next phase.
                case (phase_reg)
                    PH_ACC:
                    begin
                        if (t_s >= sx48(t1_reg))
                        begin
                            pos_next = s1_reg;
                            vel_next = act_vel_reg;
                            phase_next = PH_CRU;
                        end
                        else
                        begin
                            op_next = OP_AV;
                            state_next = ST_ISSUE;
                        end
                    end
                    PH_CRU:
                    begin
                        if (t_s >= sx48(t2_reg))
                        begin
                            pos_next = s2_reg;
                            vel_next = act_vel_reg;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            op_next = OP_CP;
                            state_next = ST_ISSUE;
                        end
                    end
                    PH_DEC:
                    begin
                        if (t_s >= sx48(t3_reg))
                        begin
                            pos_next = tgt_fix_reg;
                            vel_next = '0;
                            phase_next = PH_IDLE;
                            done_next = 1'b1;
                            elapsed_next = elapsed_inc;
                            state_next = ST_PUT;
                        end
                        else
                        begin
                            op_next = OP_DV;
                            state_next = ST_ISSUE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_PUT;
                    end
                endcase
            end

            ST_ISSUE:
            begin
                if (op_is_div)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    mul_start = 1'b1;
                end
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_T1:
                        begin
                            t1_next = div_res[POS_W-1:0];
                            op_next = OP_VV;
                        end
                        OP_VV:
                        begin
                            vv_next = mul_prod[63:0];
                            op_next = OP_S1;
                        end
                        OP_S1:
                        begin
                            s1_next = sat48(sx48(s0_reg) + zx50(div_res));
                            op_next = OP_Q;
                        end
                        OP_Q:
                        begin
                            tacc_next = dist_neg ? sx48(t1_reg) - zx50(div_res)
                                                 : sx48(t1_reg) + zx50(div_res);
                            op_next = OP_VA;
                        end
                        OP_VA:
                        begin
                            tacc_next = tacc_reg - zx50(div_res);
                            op_next = OP_VD;
                        end
                        OP_VD:
                        begin
                            t2_next = sat48(tacc_reg - zx50(div_res));
                            op_next = OP_S2;
                        end
                        OP_S2:
                        begin
                            s2_next = sat48(dt21_neg ? sx48(s1_reg) - zx50(mul_cap)
                                                     : sx48(s1_reg) + zx50(mul_cap));
                            op_next = OP_T3;
                        end
                        OP_T3:
                        begin
                            t3_next = sat48(sx48(t2_reg) + zx50(div_res));
                            elapsed_next = '0;
                            phase_next = PH_ACC;
                            state_next = ST_EVAL;
                        end
                        OP_AV:
                        begin
                            at_next = mul_cap;
                            vel_next = (mul_cap > MUL_W'(act_vel_reg)) ? act_vel_reg
                                                                      : mul_cap[VEL_W-1:0];
                            op_next = OP_AP;
                        end
                        OP_AP:
                        begin
                            pos_next = sat48(sx48(s0_reg) + zx50(mul_cap));
                            elapsed_next = elapsed_inc;
                            state_next = ST_PUT;
                        end
                        OP_CP:
                        begin
                            pos_next = sat48(sx48(s1_reg) + zx50(mul_cap));
                            vel_next = act_vel_reg;
                            elapsed_next = elapsed_inc;
                            state_next = ST_PUT;
                        end
                        OP_DV:
                        begin
                            dv_next = mul_cap;
                            vel_next = (MUL_W'(act_vel_reg) > mul_cap)
                                ? act_vel_reg - mul_cap[VEL_W-1:0] : '0;
                            op_next = OP_DF;
                        end
                        OP_DF:
                        begin
                            pos_next = sat48(sx48(s2_reg) + zx50(mul_cap));
                            op_next = OP_DB;
                        end
                        OP_DB:
                        begin
                            pos_next = sat48(sx48(pos_reg) - zx50(mul_cap));
                            elapsed_next = elapsed_inc;
                            state_next = ST_PUT;
                        end
                        default:
                        begin
                            state_next = ST_PUT;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register occupancy.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_T1;
            phase_reg <= PH_IDLE;
            pending_valid_reg <= 1'b0;
            pend_tgt_reg <= '0;
            pend_vel_reg <= '0;
            pend_acc_reg <= '0;
            pend_dec_reg <= '0;
            act_vel_reg <= '0;
            act_acc_reg <= '0;
            act_dec_reg <= '0;
            elapsed_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            tgt_fix_reg <= '0;
            pos_reg <= '0;
            vel_reg <= '0;
            done_reg <= 1'b0;
            refused_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            phase_reg <= phase_next;
            pending_valid_reg <= pending_valid_next;
            pend_tgt_reg <= pend_tgt_next;
            pend_vel_reg <= pend_vel_next;
            pend_acc_reg <= pend_acc_next;
            pend_dec_reg <= pend_dec_next;
            act_vel_reg <= act_vel_next;
            act_acc_reg <= act_acc_next;
            act_dec_reg <= act_dec_next;
            elapsed_reg <= elapsed_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            tgt_fix_reg <= tgt_fix_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            done_reg <= done_next;
            refused_reg <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scratch values of the planning and tick steps.
    always_ff @(posedge clk)
    begin
        vv_reg <= vv_next;
        tacc_reg <= tacc_next;
        at_reg <= at_next;
        dv_reg <= dv_next;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_phase_reg <= phase_reg;
            out_done_reg <= done_reg;
            out_pend_reg <= pending_valid_reg;
            out_ref_reg <= refused_reg;
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.position_setpoint = out_pos_reg;
    assign rsp.velocity_setpoint = out_vel_reg;
    assign rsp.phase = out_phase_reg;
    assign rsp.move_done = out_done_reg;
    assign rsp.move_pending = out_pend_reg;
    assign rsp.command_refused = out_ref_reg;
endmodule
